/* sv/dla_pkg.sv */
// Package for the display layout arranger.
// Holds field widths, register and alignment codes, sequencer states and the store entry type.
// No dependencies.
package dla_pkg;

    localparam int MODE_W     = 15;
    localparam int TRANS_W    = 3;
    localparam int SCALE_W    = 16;
    localparam int SIZE_W     = 23;
    localparam int POS_W      = 27;
    localparam int OUT_IDX_W  = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int ALIGN_W    = 3;

    // Rounded divide: (dim * 512 + scale) / (2 * scale)
    localparam int FRAC_SH = 9;
    localparam int NUM_W   = 25;
    localparam int DIV_W   = SCALE_W + 1;
    localparam int REM_W   = DIV_W + 1;
    localparam int STEP_W  = $clog2(NUM_W);

    localparam logic [SCALE_W-1:0] ONE_SCALE = SCALE_W'(256);
    localparam logic [SIZE_W-1:0]  SIZE_MAX  = {SIZE_W{1'b1}};
    localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_ARRANGEMENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALIGNMENT   = CFG_IDX_W'(1);

    localparam logic ARR_ROW    = 1'b0;
    localparam logic ARR_COLUMN = 1'b1;

    localparam logic [ALIGN_W-1:0] ALIGN_LEFT   = 3'd0;
    localparam logic [ALIGN_W-1:0] ALIGN_RIGHT  = 3'd1;
    localparam logic [ALIGN_W-1:0] ALIGN_MIDDLE = 3'd2;
    localparam logic [ALIGN_W-1:0] ALIGN_TOP    = 3'd3;
    localparam logic [ALIGN_W-1:0] ALIGN_BOTTOM = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_W,
        S_DIV_H,
        S_STORE,
        S_EMIT_READ,
        S_EMIT_CALC,
        S_EMIT_SEND
    } state_t;

    typedef struct packed {
        logic              en;
        logic [SIZE_W-1:0] sw;
        logic [SIZE_W-1:0] sh;
    } entry_t;

    function automatic logic [SIZE_W-1:0] sat_size(input logic [NUM_W-1:0] q);
        logic [SIZE_W-1:0] r;
        if (q > NUM_W'(SIZE_MAX))
            r = SIZE_MAX;
        else
            r = q[SIZE_W-1:0];
        return r;
    endfunction

endpackage

/* sv/dla_disp_if.sv */
// Input channel of the display layout arranger: one display description per word.
// Depends on dla_pkg.
interface dla_disp_if;
    import dla_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode_width;
    logic [MODE_W-1:0]  mode_height;
    logic [TRANS_W-1:0] transform;
    logic [SCALE_W-1:0] scale;
    logic               enabled;
    logic               last_display;

    modport source (output valid, mode_width, mode_height, transform, scale, enabled,
                    last_display, input ready);
    modport sink   (input valid, mode_width, mode_height, transform, scale, enabled,
                    last_display, output ready);
endinterface

/* sv/dla_place_if.sv */
// Result channel of the display layout arranger: one placed display per word.
// Depends on dla_pkg.
interface dla_place_if;
    import dla_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] display_index;
    logic                 placed;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [SIZE_W-1:0]    scaled_width;
    logic [SIZE_W-1:0]    scaled_height;
    logic                 last_result;

    modport source (output valid, display_index, placed, pos_x, pos_y, scaled_width,
                    scaled_height, last_result, input ready);
    modport sink   (input valid, display_index, placed, pos_x, pos_y, scaled_width,
                    scaled_height, last_result, output ready);
endinterface

/* sv/dla_cfg_if.sv */
// Configuration write channel of the display layout arranger.
// Depends on dla_pkg.
interface dla_cfg_if;
    import dla_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/display_layout_arranger_top.sv */
// Display layout arranger, top level.
// Depends on dla_pkg, dla_disp_if, dla_place_if and dla_cfg_if.
//
// Usage:
//   disp  : one word per display (mode size, transform, scale, enabled, last mark).
//   place : one word per stored display, in input order, after the last display.
//   cfg   : register writes (index 0 arrangement, 1 alignment); always ready,
//           write only while the block is idle.
// Sequence:
//   A display word is accepted in S_IDLE, divided width then height (S_DIV_W,
//   S_DIV_H) on the shared one-bit-per-cycle restoring divider, and stored in
//   S_STORE. A word that arrives with the set full skips the divider. disp.ready
//   is high only when the sequencer is idle.
//   After the last display, each result goes through store read, layout update
//   and send; send waits while the receiver holds place.ready low, and the
//   result word holds steady while stalled.
// Reset:
//   rst_n clears the sequencer, the display count, the widest/tallest trackers
//   and the registers. The display store is not cleared; only entries written in
//   the current set are read.
module display_layout_arranger_top #(
    parameter int MAX_DISPLAYS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    dla_disp_if.sink           disp,
    dla_place_if.source        place,
    dla_cfg_if.sink            cfg
);
    import dla_pkg::*;

    localparam int CNT_W = $clog2(MAX_DISPLAYS + 1);
    localparam int IDX_W = (MAX_DISPLAYS > 1) ? $clog2(MAX_DISPLAYS) : 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SIZE_W-1:0]  widest_reg;
    logic [SIZE_W-1:0]  tallest_reg;
    logic               arrangement_reg;
    logic [ALIGN_W-1:0] alignment_reg;

    logic [MODE_W-1:0]  h_in_reg;
    logic [SCALE_W-1:0] sc_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   q_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [SIZE_W-1:0]  sw_reg;
    logic               en_reg;
    logic               last_reg;
    logic [POS_W-1:0]   run_reg;
    entry_t             rd_reg;

    logic [OUT_IDX_W-1:0] o_idx_reg;
    logic                 o_placed_reg;
    logic [POS_W-1:0]     o_x_reg;
    logic [POS_W-1:0]     o_y_reg;
    logic [SIZE_W-1:0]    o_w_reg;
    logic [SIZE_W-1:0]    o_h_reg;
    logic                 o_last_reg;

    entry_t mem [MAX_DISPLAYS];

    logic               disp_acc;
    logic               full;
    logic               step_last;
    logic               final_k;
    logic [SCALE_W-1:0] sc_eff;
    logic [MODE_W-1:0]  w_sel;
    logic [MODE_W-1:0]  h_sel;
    logic [REM_W-1:0]   rem_sh;
    logic               ge;
    logic [DIV_W-1:0]   rem_new;
    logic [NUM_W-1:0]   q_new;
    logic [SIZE_W-1:0]  q_sat;
    logic [POS_W:0]     run_sum;
    logic [POS_W-1:0]   run_new;
    logic [SIZE_W-1:0]  x_slack;
    logic [SIZE_W-1:0]  y_slack;
    logic [POS_W-1:0]   cross_x;
    logic [POS_W-1:0]   cross_y;

    // Handshake and sequencer outputs
    always_comb
    begin
        disp.ready  = (state_reg == S_IDLE);
        place.valid = (state_reg == S_EMIT_SEND);
        cfg.ready   = 1'b1;
    end

    assign place.display_index = o_idx_reg;
    assign place.placed        = o_placed_reg;
    assign place.pos_x         = o_x_reg;
    assign place.pos_y         = o_y_reg;
    assign place.scaled_width  = o_w_reg;
    assign place.scaled_height = o_h_reg;
    assign place.last_result   = o_last_reg;

    assign disp_acc  = disp.valid && disp.ready;
    assign full      = (count_reg >= CNT_W'(MAX_DISPLAYS));
    assign step_last = (step_reg == STEP_W'(NUM_W - 1));
    assign final_k   = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign sc_eff    = (disp.scale == '0) ? ONE_SCALE : disp.scale;
    assign w_sel     = disp.transform[0] ? disp.mode_height : disp.mode_width;
    assign h_sel     = disp.transform[0] ? disp.mode_width : disp.mode_height;

    // Shared restoring divider step
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        ge      = (rem_sh >= REM_W'(div_reg));
        rem_new = ge ? DIV_W'(rem_sh - REM_W'(div_reg)) : rem_sh[DIV_W-1:0];
        q_new   = {q_reg[NUM_W-2:0], ge};
        q_sat   = sat_size(q_new);
    end

    // Layout arithmetic
    always_comb
    begin
        if (arrangement_reg == ARR_COLUMN)
            run_sum = POS_W'(run_reg) + (POS_W + 1)'(rd_reg.sh);
        else
            run_sum = POS_W'(run_reg) + (POS_W + 1)'(rd_reg.sw);
        run_new = run_sum[POS_W] ? POS_MAX : run_sum[POS_W-1:0];
        x_slack = widest_reg - rd_reg.sw;
        y_slack = tallest_reg - rd_reg.sh;
        cross_x = '0;
        cross_y = '0;
        if (alignment_reg == ALIGN_RIGHT)
            cross_x = POS_W'(x_slack);
        else if (alignment_reg == ALIGN_MIDDLE)
            cross_x = POS_W'(x_slack >> 1);
        if (alignment_reg == ALIGN_BOTTOM)
            cross_y = POS_W'(y_slack);
        else if (alignment_reg == ALIGN_MIDDLE)
            cross_y = POS_W'(y_slack >> 1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (disp_acc)
                begin
                    if (!full)
                        state_next = S_DIV_W;
                    else if (disp.last_display)
                        state_next = S_EMIT_READ;
                end
            end
            S_DIV_W:
            begin
                if (step_last)
                    state_next = S_DIV_H;
            end
            S_DIV_H:
            begin
                if (step_last)
                    state_next = S_STORE;
            end
            S_STORE:     state_next = last_reg ? S_EMIT_READ : S_IDLE;
            S_EMIT_READ: state_next = S_EMIT_CALC;
            S_EMIT_CALC: state_next = S_EMIT_SEND;
            S_EMIT_SEND:
            begin
                if (place.ready)
                    state_next = final_k ? S_IDLE : S_EMIT_READ;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            k_reg           <= '0;
            step_reg        <= '0;
            widest_reg      <= '0;
            tallest_reg     <= '0;
            arrangement_reg <= ARR_ROW;
            alignment_reg   <= ALIGN_LEFT;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_ARRANGEMENT: arrangement_reg <= cfg.data[0];
                    REG_ALIGNMENT:   alignment_reg   <= cfg.data[ALIGN_W-1:0];
                    default:         ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    k_reg    <= '0;
                end
                S_DIV_W, S_DIV_H:
                begin
                    step_reg <= step_last ? '0 : step_reg + STEP_W'(1);
                end
                S_STORE:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    if (en_reg)
                    begin
                        if (sw_reg > widest_reg)
                            widest_reg <= sw_reg;
                        if (q_reg[SIZE_W-1:0] > tallest_reg)
                            tallest_reg <= q_reg[SIZE_W-1:0];
                    end
                    k_reg <= '0;
                end
                S_EMIT_SEND:
                begin
                    if (place.ready)
                    begin
                        if (final_k)
                        begin
                            count_reg   <= '0;
                            widest_reg  <= '0;
                            tallest_reg <= '0;
                        end
                        else
                            k_reg <= k_reg + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (disp_acc)
                begin
                    h_in_reg <= h_sel;
                    sc_reg   <= sc_eff;
                    div_reg  <= {sc_eff, 1'b0};
                    num_reg  <= NUM_W'({w_sel, {FRAC_SH{1'b0}}}) + NUM_W'(sc_eff);
                    rem_reg  <= '0;
                    en_reg   <= disp.enabled;
                    last_reg <= disp.last_display;
                    run_reg  <= '0;
                end
            end
            S_DIV_W:
            begin
                rem_reg <= rem_new;
                q_reg   <= q_new;
                num_reg <= num_reg << 1;
                if (step_last)
                begin
                    sw_reg  <= q_sat;
                    rem_reg <= '0;
                    num_reg <= NUM_W'({h_in_reg, {FRAC_SH{1'b0}}}) + NUM_W'(sc_reg);
                end
            end
            S_DIV_H:
            begin
                rem_reg <= rem_new;
                q_reg   <= step_last ? NUM_W'(q_sat) : q_new;
                num_reg <= num_reg << 1;
            end
            S_STORE:
            begin
                mem[count_reg[IDX_W-1:0]] <= '{en: en_reg, sw: sw_reg, sh: q_reg[SIZE_W-1:0]};
                run_reg <= '0;
            end
            S_EMIT_CALC:
            begin
                o_idx_reg    <= OUT_IDX_W'(k_reg);
                o_placed_reg <= rd_reg.en;
                o_w_reg      <= rd_reg.sw;
                o_h_reg      <= rd_reg.sh;
                o_last_reg   <= final_k;
                o_x_reg      <= '0;
                o_y_reg      <= '0;
                if (rd_reg.en)
                begin
                    run_reg <= run_new;
                    if (arrangement_reg == ARR_COLUMN)
                    begin
                        o_y_reg <= run_reg;
                        o_x_reg <= cross_x;
                    end
                    else
                    begin
                        o_x_reg <= run_reg;
                        o_y_reg <= cross_y;
                    end
                end
            end
            default: ;
        endcase
        rd_reg <= mem[k_reg];
    end

`ifndef SYNTHESIS
    a_valid_in_send: assert property (@(posedge clk) disable iff (!rst_n)
        place.valid |-> (state_reg == S_EMIT_SEND))
        else $error("result word outside send state");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        disp.ready |-> !place.valid)
        else $error("display accepted while results pending");

    a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (place.valid && place.ready && place.last_result) |=>
            (count_reg == '0 && widest_reg == '0 && tallest_reg == '0))
        else $error("set not cleared after final result");

    a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (place.valid && !place.placed) |-> (place.pos_x == '0 && place.pos_y == '0))
        else $error("skipped display has nonzero position");
`endif

endmodule
